/* src/mts_pkg.sv */
package mts_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_POP_READ
  } fsm_t;

endpackage

/* src/min_tracking_stack.sv */
// Stack of signed 32-bit values that also reports the smallest value held.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. command selects push (push_value is stored), pop or read.
// Result channel: done is high for one cycle with top_value, min_value,
// held_count and status; the receiver must take it in that cycle.
//
// Timing: push, read and a pop on an empty stack give their result in the
// cycle after the command is taken, and busy stays low, so one transaction
// per cycle is possible. A pop that removes a value needs the entry below
// the old top from the value and minima RAMs, whose read data is registered,
// so busy is high for one cycle (state S_POP_READ) and the result is loaded
// from that read data; no command is taken while busy.
//
// The current tops are cached in registers; the RAMs hold every entry.
// Reset clears both counts and the cached tops; RAM contents are left as
// they are, since no entry is used before it is written.
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic signed [DATA_W-1:0]  push_value,
  output logic                      done,
  output logic signed [DATA_W-1:0]  top_value,
  output logic signed [DATA_W-1:0]  min_value,
  output logic [COUNT_W-1:0]        held_count,
  output logic [1:0]                status
);

  logic [DATA_W-1:0] value_mem [STACK_DEPTH];
  logic [DATA_W-1:0] min_mem   [STACK_DEPTH];

  fsm_t state, state_next;

  logic [COUNT_W-1:0] value_count, value_count_next;
  logic [COUNT_W-1:0] min_count, min_count_next;
  logic signed [DATA_W-1:0] top_reg, top_reg_next;
  logic signed [DATA_W-1:0] min_reg, min_reg_next;

  logic               val_we, min_we;
  logic [ADDR_W-1:0]  val_wr_addr, min_wr_addr;
  logic [ADDR_W-1:0]  val_rd_addr, min_rd_addr;
  logic [DATA_W-1:0]  val_rd_data, min_rd_data;
  logic [COUNT_W-1:0] val_rd_idx, min_rd_idx;

  logic               accept;
  logic               result_load;
  logic [1:0]         result_status;

  assign busy   = (state == S_POP_READ);
  assign accept = start && !busy;

  always_comb begin
    state_next       = state;
    value_count_next = value_count;
    min_count_next   = min_count;
    top_reg_next     = top_reg;
    min_reg_next     = min_reg;
    val_we           = 1'b0;
    min_we           = 1'b0;
    val_wr_addr      = value_count[ADDR_W-1:0];
    min_wr_addr      = min_count[ADDR_W-1:0];
    val_rd_idx       = value_count - COUNT_W'(2);
    min_rd_idx       = min_count - COUNT_W'(1);
    result_load      = 1'b0;
    result_status    = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_PUSH: begin
              result_load = 1'b1;
              if (value_count >= COUNT_W'(STACK_DEPTH)) begin
                result_status = ST_OVERFLOW;
              end else begin
                val_we           = 1'b1;
                value_count_next = value_count + COUNT_W'(1);
                top_reg_next     = push_value;
                if (min_count < COUNT_W'(STACK_DEPTH) &&
                    (min_count == '0 || push_value <= min_reg)) begin
                  min_we         = 1'b1;
                  min_count_next = min_count + COUNT_W'(1);
                  min_reg_next   = push_value;
                end
              end
            end
            CMD_POP: begin
              if (value_count == '0) begin
                result_load   = 1'b1;
                result_status = ST_UNDERFLOW;
              end else begin
                value_count_next = value_count - COUNT_W'(1);
                // drop the minimum too when the popped value is it
                if (min_count != '0 && min_reg == top_reg) begin
                  min_count_next = min_count - COUNT_W'(1);
                  min_rd_idx     = min_count - COUNT_W'(2);
                end
                state_next = S_POP_READ;
              end
            end
            default: begin
              result_load = 1'b1;
            end
          endcase
        end
      end
      S_POP_READ: begin
        top_reg_next = val_rd_data;
        min_reg_next = min_rd_data;
        result_load  = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    val_rd_addr = val_rd_idx[ADDR_W-1:0];
    min_rd_addr = min_rd_idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_wr_addr] <= push_value;
    end
    if (min_we) begin
      min_mem[min_wr_addr] <= push_value;
    end
    val_rd_data <= value_mem[val_rd_addr];
    min_rd_data <= min_mem[min_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      value_count <= '0;
      min_count   <= '0;
      top_reg     <= '0;
      min_reg     <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      value_count <= value_count_next;
      min_count   <= min_count_next;
      top_reg     <= top_reg_next;
      min_reg     <= min_reg_next;
      done        <= result_load;
    end
  end

  // result payload, valid while done is high
  always_ff @(posedge clk) begin
    if (result_load) begin
      held_count <= value_count_next;
      status     <= result_status;
      top_value  <= (value_count_next != '0) ? top_reg_next : '0;
      min_value  <= (value_count_next != '0 && min_count_next != '0) ? min_reg_next : '0;
    end
  end

  a_min_le_count: assert property (@(posedge clk) disable iff (rst)
    min_count <= value_count)
    else $error("minima count exceeds value count");

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("pop read did not finish in one cycle");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OVERFLOW |-> held_count == COUNT_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && held_count == '0 |-> top_value == '0 && min_value == '0)
    else $error("empty stack reports non-zero top or minimum");

  a_min_held: assert property (@(posedge clk) disable iff (rst)
    value_count != '0 |-> min_count != '0)
    else $error("values held with no recorded minimum");

endmodule
